// ===== src/asc_pkg.sv =====
// Shared types, constants and helpers for the analog stick conditioner.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package asc_pkg;

	// stick sample and axis widths
	localparam int STICK_W = 9;
	localparam int AXIS_W  = 16;
	localparam int MASK_W  = 4;
	localparam int NUM_AXES = 4;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DZ  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DZ = 1'b1;
	localparam logic [CFG_DATA_W-1:0] LEFT_DZ_RST  = 8'd15;
	localparam logic [CFG_DATA_W-1:0] RIGHT_DZ_RST = 8'd25;

	// scale constants
	localparam logic [7:0] FULL_SCALE = 8'd180;
	localparam logic signed [25:0] AXIS_GAIN = 26'sd180;

	// shared compare/subtract unit width
	localparam int CS_W = 26;

	// iteration counts: one root bit per step, one quotient bit per step
	localparam int SQRT_STEPS = 17;
	localparam int DIV_STEPS  = 16;
	localparam int CNT_W = 5;

	// axis slots in the stored-value array and the changed mask
	localparam int AX_SIDE  = 0;
	localparam int AX_FWD   = 1;
	localparam int AX_PITCH = 2;
	localparam int AX_YAW   = 3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_SQRT,
		ST_PREP,
		ST_MULX,
		ST_DIVX,
		ST_MULY,
		ST_DIVY,
		ST_SIGN,
		ST_FINAL
	} asc_state_t;

	// operands and result of the compare/subtract unit
	typedef struct packed {
		logic [CS_W-1:0] a;
		logic [CS_W-1:0] b;
	} asc_cs_req_t;

	typedef struct packed {
		logic            ge;
		logic [CS_W-1:0] diff;
	} asc_cs_rsp_t;

	// clamp a wide signed product to the signed 16-bit axis range
	function automatic logic signed [AXIS_W-1:0] sat16(input logic signed [25:0] v);
		logic signed [AXIS_W-1:0] r;
		if (v > 26'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -26'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[AXIS_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/asc_if.sv =====
// Valid/ready channel interfaces for the stick sample and the axis word.
// Depends on asc_pkg for field widths.
`default_nettype none

interface asc_in_if;
	import asc_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [STICK_W-1:0]  left_stick_x;
	logic signed [STICK_W-1:0]  left_stick_y;
	logic signed [STICK_W-1:0]  right_stick_x;
	logic signed [STICK_W-1:0]  right_stick_y;

	modport source (output valid, output left_stick_x, output left_stick_y,
		output right_stick_x, output right_stick_y, input ready);
	modport sink (input valid, input left_stick_x, input left_stick_y,
		input right_stick_x, input right_stick_y, output ready);
endinterface

interface asc_out_if;
	import asc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [AXIS_W-1:0]  side_axis;
	logic signed [AXIS_W-1:0]  forward_axis;
	logic signed [AXIS_W-1:0]  pitch_axis;
	logic signed [AXIS_W-1:0]  yaw_axis;
	logic [MASK_W-1:0]         changed_mask;

	modport source (output valid, output side_axis, output forward_axis,
		output pitch_axis, output yaw_axis, output changed_mask, input ready);
	modport sink (input valid, input side_axis, input forward_axis,
		input pitch_axis, input yaw_axis, input changed_mask, output ready);
endinterface

`default_nettype wire

// ===== src/asc_csub.sv =====
// Compare/subtract unit shared by the square root and the divider steps.
// Depends on asc_pkg for the request/response structs.
`default_nettype none

module asc_csub (
	input  asc_pkg::asc_cs_req_t req,
	output asc_pkg::asc_cs_rsp_t rsp
);
	import asc_pkg::*;

	// one trial subtraction: keep the difference when a >= b
	always_comb begin
		rsp.ge   = (req.a >= req.b);
		rsp.diff = req.a - req.b;
	end

endmodule

`default_nettype wire

// ===== src/analog_stick_conditioner.sv =====
// Top level of the analog stick conditioner: sequencer, datapath, output word.
// Depends on asc_pkg, asc_if (channel interfaces) and asc_csub.
//
// Usage:
//   stick  - sink channel, one raw two-stick sample per word.
//   axes   - source channel, one conditioned axis word per sample, with a
//            changed mask against the previous word's axis values.
//   cfg_*  - register writes (index 0 left dead zone, 1 right dead zone),
//            taken on any edge with cfg_we high; write only while idle.
// Sequence: a sample is handled by one compare/subtract unit under a small
//   sequencer: a squaring step, 17 root steps, a setup step, then per right
//   axis a multiply step and 16 quotient steps, a sign step, an output step.
//   The result word shows as stick.ready rises. A right stick inside its
//   dead zone skips the multiply, divide and sign steps.
// Stall: the result sits in an output register; the next sample is taken
//   while it waits, and only the final load waits for axes.ready.
// Reset: dead zones return to 15 and 25, stored axis values to zero, and
//   both channels go idle.
`default_nettype none

module analog_stick_conditioner (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [asc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [asc_pkg::CFG_DATA_W-1:0]    cfg_data,
	asc_in_if.sink                            stick,
	asc_out_if.source                         axes
);
	import asc_pkg::*;

	asc_state_t state_q, state_d;

	logic [CFG_DATA_W-1:0] left_dz_q, right_dz_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  out_valid_q;
	logic [AXIS_W-1:0]     last_q [NUM_AXES];

	// datapath registers
	logic signed [STICK_W-1:0] rx_q, ry_q;
	logic signed [AXIS_W-1:0]  side_q, fwd_q;
	logic [33:0]               n_q;
	logic [CS_W-1:0]           rem_q;
	logic [16:0]               root_q;
	logic [16:0]               diff_q;
	logic [24:0]               den_q;
	logic [15:0]               ax_q, ay_q;
	logic                      negx_q, negy_q;
	logic [15:0]               numlo_q;
	logic [15:0]               quot_q;
	logic signed [16:0]        sx_q, sy_q;

	// output word registers
	logic signed [AXIS_W-1:0]  o_side_q, o_fwd_q, o_pitch_q, o_yaw_q;
	logic [MASK_W-1:0]         o_mask_q;

	// control outputs
	logic        in_ready;
	logic        accept;
	logic        out_load;
	logic        right_zero;
	asc_cs_req_t cs_req;
	asc_cs_rsp_t cs_rsp;

	// shared compare/subtract unit
	asc_csub u_csub (
		.req (cs_req),
		.rsp (cs_rsp)
	);

	// left stick: per-axis dead zone and gain
	logic [STICK_W-1:0]        lx_abs, ly_abs;
	logic signed [STICK_W-1:0] lx_eff, ly_eff;
	logic signed [25:0]        side_prod, fwd_prod;

	always_comb begin
		lx_abs = stick.left_stick_x[STICK_W-1] ? STICK_W'(-stick.left_stick_x)
			: stick.left_stick_x;
		ly_abs = stick.left_stick_y[STICK_W-1] ? STICK_W'(-stick.left_stick_y)
			: stick.left_stick_y;
		lx_eff = (lx_abs < {1'b0, left_dz_q}) ? '0 : stick.left_stick_x;
		ly_eff = (ly_abs < {1'b0, left_dz_q}) ? '0 : stick.left_stick_y;
		side_prod = lx_eff * AXIS_GAIN;
		fwd_prod  = -(ly_eff * AXIS_GAIN);
	end

	// right stick: squared magnitude
	logic signed [17:0] sqx, sqy;
	logic [17:0]        sq_sum;

	always_comb begin
		sqx = rx_q * rx_q;
		sqy = ry_q * ry_q;
		sq_sum = 18'(sqx) + 18'(sqy);
	end

	// right stick: dead-zone edge, denominator and scaled components
	logic [15:0] edge_v;
	logic [8:0]  rx_abs, ry_abs;
	logic [7:0]  span;
	logic [33:0] num_x, num_y;
	logic [24:0] den_v;
	logic [15:0] ax_v, ay_v;

	always_comb begin
		edge_v = {right_dz_q, 8'd0};
		span   = FULL_SCALE - right_dz_q;
		right_zero = (right_dz_q >= FULL_SCALE) || (root_q == '0)
			|| (root_q < {1'b0, edge_v});
		rx_abs = rx_q[STICK_W-1] ? 9'(-rx_q) : 9'(rx_q);
		ry_abs = ry_q[STICK_W-1] ? 9'(-ry_q) : 9'(ry_q);
		ax_v   = 16'(rx_abs * FULL_SCALE);
		ay_v   = 16'(ry_abs * FULL_SCALE);
		den_v  = 25'(root_q * span);
		num_x  = 34'(ax_q * diff_q);
		num_y  = 34'(ay_q * diff_q);
	end

	// final right-axis gain
	logic signed [25:0] pitch_prod, yaw_prod;
	logic signed [AXIS_W-1:0] pitch_v, yaw_v, side_v, fwd_v;

	always_comb begin
		pitch_prod = -(sx_q * AXIS_GAIN);
		yaw_prod   = sy_q * AXIS_GAIN;
		pitch_v    = sat16(pitch_prod);
		yaw_v      = sat16(yaw_prod);
		side_v     = side_q;
		fwd_v      = fwd_q;
	end

	// sequencer outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_load = (state_q == ST_FINAL) && (!out_valid_q || axes.ready);
		case (state_q)
			ST_SQRT: begin
				cs_req.a = {rem_q[23:0], n_q[33:32]};
				cs_req.b = {7'd0, root_q, 2'b01};
			end
			ST_DIVX, ST_DIVY: begin
				cs_req.a = {rem_q[24:0], numlo_q[15]};
				cs_req.b = {1'b0, den_q};
			end
			default: begin
				cs_req.a = '0;
				cs_req.b = '0;
			end
		endcase
	end

	assign accept = stick.valid && in_ready;

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_d = ST_SQUARE;
			ST_SQUARE: state_d = ST_SQRT;
			ST_SQRT: begin
				if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_d = ST_PREP;
			end
			ST_PREP:   state_d = right_zero ? ST_FINAL : ST_MULX;
			ST_MULX:   state_d = ST_DIVX;
			ST_DIVX: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_MULY;
			end
			ST_MULY:   state_d = ST_DIVY;
			ST_DIVY: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_SIGN;
			end
			ST_SIGN:   state_d = ST_FINAL;
			ST_FINAL:  if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			left_dz_q   <= LEFT_DZ_RST;
			right_dz_q  <= RIGHT_DZ_RST;
			for (int i = 0; i < NUM_AXES; i++) last_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SQRT || state_q == ST_DIVX || state_q == ST_DIVY) begin
				cnt_q <= (state_d == state_q) ? cnt_q + 1'b1 : '0;
			end else begin
				cnt_q <= '0;
			end
			if (cfg_we) begin
				case (cfg_idx)
					CFG_LEFT_DZ:  left_dz_q  <= cfg_data;
					CFG_RIGHT_DZ: right_dz_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				last_q[AX_SIDE]  <= side_v;
				last_q[AX_FWD]   <= fwd_v;
				last_q[AX_PITCH] <= pitch_v;
				last_q[AX_YAW]   <= yaw_v;
			end else if (axes.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rx_q   <= stick.right_stick_x;
					ry_q   <= stick.right_stick_y;
					side_q <= sat16(side_prod);
					fwd_q  <= sat16(fwd_prod);
				end
			end
			ST_SQUARE: begin
				n_q    <= {sq_sum, 16'd0};
				rem_q  <= '0;
				root_q <= '0;
			end
			// one root bit per step
			ST_SQRT: begin
				rem_q  <= cs_rsp.ge ? cs_rsp.diff : cs_req.a;
				root_q <= {root_q[15:0], cs_rsp.ge};
				n_q    <= {n_q[31:0], 2'b00};
			end
			ST_PREP: begin
				diff_q <= root_q - {1'b0, edge_v};
				den_q  <= den_v;
				ax_q   <= ax_v;
				ay_q   <= ay_v;
				negx_q <= rx_q[STICK_W-1];
				negy_q <= ry_q[STICK_W-1];
				sx_q   <= '0;
				sy_q   <= '0;
			end
			// quotient is below 2^16, so the upper numerator bits start as remainder
			ST_MULX: begin
				rem_q   <= {8'd0, num_x[33:16]};
				numlo_q <= num_x[15:0];
				quot_q  <= '0;
			end
			ST_DIVX, ST_DIVY: begin
				rem_q   <= cs_rsp.ge ? cs_rsp.diff : cs_req.a;
				quot_q  <= {quot_q[14:0], cs_rsp.ge};
				numlo_q <= {numlo_q[14:0], 1'b0};
			end
			ST_MULY: begin
				sx_q    <= negx_q ? -$signed({1'b0, quot_q}) : $signed({1'b0, quot_q});
				rem_q   <= {8'd0, num_y[33:16]};
				numlo_q <= num_y[15:0];
				quot_q  <= '0;
			end
			ST_SIGN: begin
				sy_q <= negy_q ? -$signed({1'b0, quot_q}) : $signed({1'b0, quot_q});
			end
			ST_FINAL: begin
				if (out_load) begin
					o_side_q  <= side_v;
					o_fwd_q   <= fwd_v;
					o_pitch_q <= pitch_v;
					o_yaw_q   <= yaw_v;
					o_mask_q  <= {yaw_v != last_q[AX_YAW], pitch_v != last_q[AX_PITCH],
						fwd_v != last_q[AX_FWD], side_v != last_q[AX_SIDE]};
				end
			end
			default: ;
		endcase
	end

	// channel ports
	assign stick.ready       = in_ready;
	assign axes.valid        = out_valid_q;
	assign axes.side_axis    = o_side_q;
	assign axes.forward_axis = o_fwd_q;
	assign axes.pitch_axis   = o_pitch_q;
	assign axes.yaw_axis     = o_yaw_q;
	assign axes.changed_mask = o_mask_q;

endmodule

`default_nettype wire

// ===== src/asc_checker.sv =====
// Port-level assertions for the analog stick conditioner, bound to the top.
// Depends on asc_pkg for widths and on the analog_stick_conditioner ports.
`default_nettype none

module asc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [asc_pkg::AXIS_W-1:0] side,
	input logic signed [asc_pkg::AXIS_W-1:0] fwd,
	input logic signed [asc_pkg::AXIS_W-1:0] pitch,
	input logic signed [asc_pkg::AXIS_W-1:0] yaw,
	input logic [asc_pkg::MASK_W-1:0]        mask
);
	import asc_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// one sample at a time: busy right after taking one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("sample channel ready right after a sample was taken");

	// a result never appears the cycle after its sample is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !$rose(out_valid))
		else $error("result word appeared one cycle after a sample");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(side) && $stable(fwd)
			&& $stable(pitch) && $stable(yaw) && $stable(mask))
		else $error("stalled result word changed");

	// a new word appears only while the sample side is idle again
	a_result_then_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result word appeared while a sample was still in work");

endmodule

bind analog_stick_conditioner asc_checker u_asc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (stick.valid),
	.in_ready  (stick.ready),
	.out_valid (axes.valid),
	.out_ready (axes.ready),
	.side      (axes.side_axis),
	.fwd       (axes.forward_axis),
	.pitch     (axes.pitch_axis),
	.yaw       (axes.yaw_axis),
	.mask      (axes.changed_mask)
);

`default_nettype wire
